// File: src/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and constants of the sorted timer scheduler.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int MAX_TIMERS = 32;
  localparam int SLOT_W     = 5;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

  localparam logic [31:0] WRAP_NEAR_ZERO = 32'h0800_0000;
  localparam logic [31:0] WRAP_NEAR_TOP  = 32'hF800_0000;

  localparam logic [15:0] MIN_WAIT_RST   = 16'd50;
  localparam logic [15:0] MAX_WAIT_RST   = 16'd500;
  localparam logic [15:0] LATE_LIMIT_RST = 16'd1000;
  localparam logic [15:0] IDLE_WAIT_RST  = 16'd1000;

  // input command codes
  localparam logic [2:0] CMD_ADD_ONE = 3'd0;
  localparam logic [2:0] CMD_ADD_PER = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_DELAY   = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_WAIT   = 2'd0;
  localparam logic [1:0] REG_MAX_WAIT   = 2'd1;
  localparam logic [1:0] REG_LATE_LIMIT = 2'd2;
  localparam logic [1:0] REG_IDLE_WAIT  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_SLOT   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;
  localparam logic [1:0] KIND_WAIT   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TIMER = 2'd1;
  localparam logic [1:0] ST_OWNER    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // slot modes
  localparam logic [1:0] MODE_FREE = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_PER  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD_ONE,
    OP_ADD_PER,
    OP_CANCEL,
    OP_DELAY,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] tval;
    logic [30:0] per;
    logic [4:0]  slot;
    logic [31:0] user;
    logic [15:0] owner;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [31:0] user;
    logic [31:0] tval;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_INS_SCAN,
    S_REM_SCAN,
    S_TK_HEAD,
    S_TK_EVAL,
    S_TK_RETIRE,
    S_EMIT
  } eng_state_t;

  // clamp a nonnegative wait into [min, max], the min test made first
  function automatic logic [31:0] clamp_wait(input logic [31:0] w,
                                             input logic [15:0] lo,
                                             input logic [15:0] hi);
    logic [31:0] r;
    if (w < {16'd0, lo}) r = {16'd0, lo};
    else if (w > {16'd0, hi}) r = {16'd0, hi};
    else r = w;
    return r;
  endfunction

endpackage

// File: src/sts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// Accepts input words, decodes the command and drops unknown codes.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] time_value,
  input  logic [30:0] period,
  input  logic [4:0]  timer_slot,
  input  logic [31:0] user_id,
  input  logic [15:0] owner_tag,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  logic known;
  op_t  op;

  // decode the command code
  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    unique case (command)
      CMD_ADD_ONE: op = OP_ADD_ONE;
      CMD_ADD_PER: op = OP_ADD_PER;
      CMD_CANCEL:  op = OP_CANCEL;
      CMD_DELAY:   op = OP_DELAY;
      CMD_TICK:    op = OP_TICK;
      default:     known = 1'b0;
    endcase
  end

  // hold off while the queue is full; unknown words are taken and dropped
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;

  assign q_data.op    = op;
  assign q_data.tval  = time_value;
  assign q_data.per   = period;
  assign q_data.slot  = timer_slot;
  assign q_data.user  = user_id;
  assign q_data.owner = owner_tag;

endmodule

// File: src/sts_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_cmd_queue
// Two-entry command queue between the front and the engine.
// ----------------------------------------------------------------------------
module sts_cmd_queue import sts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = entry[rd_ptr];

  // store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/sts_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_engine
// Slot table, sorted queue and sequencer that carries out commands.
// ----------------------------------------------------------------------------
module sts_engine import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output res_t        out_res
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TIMERS);

  // configuration
  logic [15:0] min_wait, max_wait, late_limit, idle_wait;

  // slot table
  logic [1:0]        mode   [MAX_TIMERS];
  logic              canc   [MAX_TIMERS];
  logic [31:0]       due    [MAX_TIMERS];
  logic [30:0]       per    [MAX_TIMERS];
  logic [31:0]       utag   [MAX_TIMERS];
  logic [15:0]       owner  [MAX_TIMERS];
  logic [SLOT_W-1:0] olist  [MAX_TIMERS];
  logic [SLOT_W-1:0] fstack [MAX_TIMERS];
  logic [CNT_W-1:0]  ocount, fcount, hw;

  // sequencer
  eng_state_t        state, state_next;
  cmd_t              cmd;
  logic [CNT_W-1:0]  pos, taken;
  logic [SLOT_W-1:0] ins_slot;
  logic [31:0]       ins_due;
  res_t              resp;

  // shared conditions
  logic [SLOT_W-1:0] q_slot, tail_slot;
  logic [31:0]       q_due, tail_due, ins_diff, tk_diff, fire, new_due;
  logic              scan_end, ins_go_on, rem_hit, wrap_hit, diff_pos, is_late;
  logic              slot_bad, can_emit;
  logic [CNT_W-1:0]  ocount_m1, fcount_m1;
  logic [1:0]        cancel_st;

  assign ocount_m1 = ocount - CNT_W'(1);
  assign fcount_m1 = fcount - CNT_W'(1);
  assign q_slot    = olist[pos[SLOT_W-1:0]];
  assign q_due     = due[q_slot];
  assign tail_slot = olist[ocount_m1[SLOT_W-1:0]];
  assign tail_due  = due[tail_slot];
  assign scan_end  = pos == ocount;
  assign ins_diff  = q_due - ins_due;
  assign ins_go_on = !scan_end && (ins_diff[31] || ins_diff == 32'd0);
  assign rem_hit   = !scan_end && q_slot == cmd.slot;
  assign wrap_hit  = cmd.tval < WRAP_NEAR_ZERO &&
                     (tail_due == 32'd0 || tail_due > WRAP_NEAR_TOP);
  assign tk_diff   = q_due - cmd.tval;
  assign diff_pos  = !tk_diff[31] && tk_diff != 32'd0;
  assign is_late   = $signed({{2{tk_diff[31]}}, tk_diff}) < -$signed({18'd0, late_limit});
  assign fire      = is_late ? cmd.tval : q_due;
  assign new_due   = due[cmd.slot] + cmd.tval;
  assign slot_bad  = {1'b0, cmd.slot} >= hw || mode[cmd.slot] == MODE_FREE;
  assign can_emit  = !out_valid || !out_stall;
  assign q_pop     = state == S_IDLE && q_valid;

  // status of a cancel at the queue head
  always_comb begin
    if ({1'b0, q_head.slot} >= hw || mode[q_head.slot] == MODE_FREE) begin
      cancel_st = ST_NO_TIMER;
    end else if (canc[q_head.slot] || owner[q_head.slot] != q_head.owner) begin
      cancel_st = ST_OWNER;
    end else begin
      cancel_st = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_head.op)
            OP_ADD_ONE, OP_ADD_PER: state_next = S_ALLOC;
            OP_CANCEL:              state_next = S_EMIT;
            OP_DELAY:               state_next = S_REM_SCAN;
            OP_TICK:                state_next = S_TK_HEAD;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (fcount == '0 && hw == MAX_CNT) state_next = S_EMIT;
        else state_next = S_INS_SCAN;
      end
      S_INS_SCAN: begin
        if (ocount == MAX_CNT || !ins_go_on) begin
          state_next = (cmd.op == OP_TICK) ? S_TK_HEAD : S_EMIT;
        end
      end
      S_REM_SCAN: begin
        if (slot_bad) state_next = S_EMIT;
        else if (scan_end || rem_hit) state_next = S_INS_SCAN;
      end
      S_TK_HEAD: begin
        state_next = (ocount == '0) ? S_EMIT : S_TK_EVAL;
      end
      S_TK_EVAL: begin
        if (diff_pos || taken == MAX_CNT || !canc[q_slot]) state_next = S_EMIT;
        else state_next = S_TK_RETIRE;
      end
      S_TK_RETIRE: begin
        state_next = (mode[ins_slot] == MODE_PER) ? S_INS_SCAN : S_TK_HEAD;
      end
      S_EMIT: begin
        if (can_emit) state_next = resp.last ? S_IDLE : S_TK_RETIRE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_wait   <= MIN_WAIT_RST;
      max_wait   <= MAX_WAIT_RST;
      late_limit <= LATE_LIMIT_RST;
      idle_wait  <= IDLE_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_WAIT:   min_wait   <= cfg_data;
        REG_MAX_WAIT:   max_wait   <= cfg_data;
        REG_LATE_LIMIT: late_limit <= cfg_data;
        REG_IDLE_WAIT:  idle_wait  <= cfg_data;
        default:        min_wait   <= min_wait;
      endcase
    end
  end

  // control state: modes, marks, counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TIMERS; i++) begin
        mode[i] <= MODE_FREE;
        canc[i] <= 1'b0;
      end
      ocount <= '0;
      fcount <= '0;
      hw     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_head.op == OP_CANCEL && cancel_st == ST_OK) begin
            mode[q_head.slot] <= MODE_ONE;
            canc[q_head.slot] <= 1'b1;
          end
        end
        S_ALLOC: begin
          if (fcount != '0) begin
            fcount <= fcount_m1;
            mode[fstack[fcount_m1[SLOT_W-1:0]]] <= (cmd.op == OP_ADD_PER) ? MODE_PER : MODE_ONE;
            canc[fstack[fcount_m1[SLOT_W-1:0]]] <= 1'b0;
          end else if (hw != MAX_CNT) begin
            hw <= hw + CNT_W'(1);
            mode[hw[SLOT_W-1:0]] <= (cmd.op == OP_ADD_PER) ? MODE_PER : MODE_ONE;
            canc[hw[SLOT_W-1:0]] <= 1'b0;
          end
        end
        S_INS_SCAN: begin
          if (ocount != MAX_CNT && !ins_go_on) ocount <= ocount + CNT_W'(1);
        end
        S_REM_SCAN: begin
          if (rem_hit) ocount <= ocount_m1;
        end
        S_TK_EVAL: begin
          if (!diff_pos && taken != MAX_CNT) ocount <= ocount_m1;
        end
        S_TK_RETIRE: begin
          if (mode[ins_slot] != MODE_PER) begin
            mode[ins_slot] <= MODE_FREE;
            canc[ins_slot] <= 1'b0;
            if (fcount != MAX_CNT) fcount <= fcount + CNT_W'(1);
          end
        end
        default: ocount <= ocount;
      endcase
    end
  end

  // slot payload, queue order and free stack
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cmd   <= q_head;
          pos   <= '0;
          taken <= '0;
        end
      end
      S_ALLOC: begin
        if (fcount != '0) ins_slot <= fstack[fcount_m1[SLOT_W-1:0]];
        else ins_slot <= hw[SLOT_W-1:0];
        if (fcount != '0 || hw != MAX_CNT) begin
          due[(fcount != '0) ? fstack[fcount_m1[SLOT_W-1:0]] : hw[SLOT_W-1:0]]   <= cmd.tval;
          per[(fcount != '0) ? fstack[fcount_m1[SLOT_W-1:0]] : hw[SLOT_W-1:0]]   <= cmd.per;
          utag[(fcount != '0) ? fstack[fcount_m1[SLOT_W-1:0]] : hw[SLOT_W-1:0]]  <= cmd.user;
          owner[(fcount != '0) ? fstack[fcount_m1[SLOT_W-1:0]] : hw[SLOT_W-1:0]] <= cmd.owner;
        end
        ins_due <= cmd.tval;
        pos     <= '0;
      end
      S_INS_SCAN: begin
        if (ocount != MAX_CNT && ins_go_on) begin
          pos <= pos + CNT_W'(1);
        end else if (ocount != MAX_CNT) begin
          // open a gap at pos and drop the slot in
          for (int i = 1; i < MAX_TIMERS; i++) begin
            if (i > int'(pos)) olist[i] <= olist[i-1];
          end
          olist[pos[SLOT_W-1:0]] <= ins_slot;
        end
      end
      S_REM_SCAN: begin
        if (!slot_bad && (scan_end || rem_hit)) begin
          if (rem_hit) begin
            for (int i = 0; i < MAX_TIMERS - 1; i++) begin
              if (i >= int'(pos)) olist[i] <= olist[i+1];
            end
          end
          due[cmd.slot] <= new_due;
          ins_slot      <= cmd.slot;
          ins_due       <= new_due;
          pos           <= '0;
        end else begin
          pos <= pos + CNT_W'(1);
        end
      end
      S_TK_HEAD: begin
        if (ocount != '0 && wrap_hit) begin
          due[tail_slot] <= 32'd0;
          pos            <= ocount_m1;
        end else begin
          pos <= '0;
        end
      end
      S_TK_EVAL: begin
        if (!diff_pos && taken != MAX_CNT) begin
          for (int i = 0; i < MAX_TIMERS - 1; i++) begin
            if (i >= int'(pos)) olist[i] <= olist[i+1];
          end
          taken    <= taken + CNT_W'(1);
          ins_slot <= q_slot;
          ins_due  <= fire;
        end
      end
      S_TK_RETIRE: begin
        if (mode[ins_slot] == MODE_PER) begin
          due[ins_slot] <= ins_due + {1'b0, per[ins_slot]};
          ins_due       <= ins_due + {1'b0, per[ins_slot]};
          pos           <= '0;
        end else if (fcount != MAX_CNT) begin
          fstack[fcount[SLOT_W-1:0]] <= ins_slot;
        end
      end
      default: pos <= pos;
    endcase
  end

  // build the pending result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        resp <= '{kind: KIND_STATUS, status: cancel_st, slot: q_head.slot,
                  user: 32'd0, tval: 32'd0, last: 1'b1};
      end
      S_ALLOC: begin
        resp <= '{kind: KIND_STATUS, status: ST_FULL, slot: 5'd0,
                  user: 32'd0, tval: 32'd0, last: 1'b1};
      end
      S_INS_SCAN: begin
        if (cmd.op == OP_DELAY) begin
          resp <= '{kind: KIND_STATUS, status: ST_OK, slot: ins_slot,
                    user: 32'd0, tval: ins_due, last: 1'b1};
        end else begin
          resp <= '{kind: KIND_SLOT, status: ST_OK, slot: ins_slot,
                    user: 32'd0, tval: 32'd0, last: 1'b1};
        end
      end
      S_REM_SCAN: begin
        // delay of an unknown slot answers straight away
        if (slot_bad) begin
          resp <= '{kind: KIND_STATUS, status: ST_NO_TIMER, slot: cmd.slot,
                    user: 32'd0, tval: 32'd0, last: 1'b1};
        end
      end
      S_TK_HEAD: begin
        resp <= '{kind: KIND_WAIT, status: ST_OK, slot: 5'd0, user: 32'd0,
                  tval: clamp_wait({16'd0, idle_wait}, min_wait, max_wait), last: 1'b1};
      end
      S_TK_EVAL: begin
        if (diff_pos) begin
          resp <= '{kind: KIND_WAIT, status: ST_OK, slot: 5'd0, user: 32'd0,
                    tval: clamp_wait(tk_diff, min_wait, max_wait), last: 1'b1};
        end else if (taken == MAX_CNT) begin
          resp <= '{kind: KIND_WAIT, status: ST_OK, slot: 5'd0, user: 32'd0,
                    tval: clamp_wait(32'd0, min_wait, max_wait), last: 1'b1};
        end else begin
          resp <= '{kind: KIND_EXPIRY, status: ST_OK, slot: q_slot,
                    user: utag[q_slot], tval: fire, last: 1'b0};
        end
      end
      default: resp <= resp;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && can_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && can_emit) out_res <= resp;
  end

endmodule

// File: src/sorted_timer_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_scheduler
// Timer slot table with a due-time sorted queue and periodic reload.
// ----------------------------------------------------------------------------
// Commands are taken by a front stage into a two-word queue and carried out
// one at a time by a sequencer over the slot table. Cancel gives one result
// word. Add takes a slot and inserts it into the sorted queue; delay first
// searches the queue for the slot and then inserts it anew. The sorted
// insertion and the slot search each step through one queue position per
// cycle; a delay of an unknown slot answers straight from the search. A tick
// fires the due timers from the head of the queue, one word for each that is
// not cancelled, and reinserts a periodic one with a further insertion
// walk; it ends with one wait word. Each result word waits in the emit state
// until the output register can take it.
// ----------------------------------------------------------------------------
module sorted_timer_scheduler import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] time_value,
  input  logic [30:0] period,
  input  logic [4:0]  timer_slot,
  input  logic [31:0] user_id,
  input  logic [15:0] owner_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [1:0]  status,
  output logic [4:0]  slot_out,
  output logic [31:0] user_out,
  output logic [31:0] time_out,
  output logic        last
);

  logic q_push, q_pop, q_full, q_valid;
  cmd_t q_in, q_head;
  res_t res;

  sts_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .time_value(time_value),
    .period    (period),
    .timer_slot(timer_slot),
    .user_id   (user_id),
    .owner_tag (owner_tag),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  sts_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_valid),
    .head     (q_head)
  );

  sts_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res)
  );

  assign result_kind = res.kind;
  assign status      = res.status;
  assign slot_out    = res.slot;
  assign user_out    = res.user;
  assign time_out    = res.tval;
  assign last        = res.last;

endmodule

// File: dv/sorted_timer_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_scheduler_tb
// Self-checking bench for the sorted timer scheduler. A directed table covers
// reset values, field extremes, every command, owner checks, the wrap fix and
// late firing; a fill phase covers a full table. Random phases with register
// changes follow. Every result word is checked against a timer-queue model.
// ----------------------------------------------------------------------------
module sorted_timer_scheduler_tb;
  import sts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] tval;
    logic [30:0] per;
    logic [4:0]  slot;
    logic [31:0] user;
    logic [15:0] owner;
    bit          has_fixed;
    res_t        fixed;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [31:0] time_value;
  logic [30:0] period;
  logic [4:0]  timer_slot;
  logic [31:0] user_id;
  logic [15:0] owner_tag;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  result_kind;
  logic [1:0]  status;
  logic [4:0]  slot_out;
  logic [31:0] user_out;
  logic [31:0] time_out;
  logic        last;

  // scheduler model state
  logic [31:0] m_due [MAX_TIMERS];
  logic [30:0] m_reload [MAX_TIMERS];
  logic [31:0] m_user [MAX_TIMERS];
  logic [15:0] m_owner [MAX_TIMERS];
  logic [1:0]  m_mode [MAX_TIMERS];
  bit          m_cancelled [MAX_TIMERS];
  int          m_order [$];
  int          m_free [$];
  int          m_high;
  logic [15:0] m_min, m_max, m_late, m_idle;

  res_t        expected_words [$];
  int          errors;
  int          quiet_cycles;
  bit          hold_off_req;
  bit          all_sent;
  logic [31:0] clock_now;

  sorted_timer_scheduler DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint wrap_diff(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return longint'($signed(d));
  endfunction

  function automatic res_t mk_word(logic [1:0] k, logic [1:0] st, logic [4:0] s,
                                   logic [31:0] u, logic [31:0] t, logic l);
    res_t r;
    r.kind = k; r.status = st; r.slot = s; r.user = u; r.tval = t; r.last = l;
    return r;
  endfunction

  // insert behind all equal due times
  function automatic void order_insert(int s);
    int pos;
    pos = 0;
    while (pos < m_order.size() && wrap_diff(m_due[m_order[pos]], m_due[s]) <= 0)
      pos++;
    m_order.insert(pos, s);
  endfunction

  function automatic void release_slot(int s);
    m_mode[s] = MODE_FREE;
    m_cancelled[s] = 0;
    m_free.push_back(s);
  endfunction

  function automatic void set_register(logic [1:0] idx, logic [15:0] v);
    case (idx)
      REG_MIN_WAIT:   m_min = v;
      REG_MAX_WAIT:   m_max = v;
      REG_LATE_LIMIT: m_late = v;
      default:        m_idle = v;
    endcase
  endfunction

  // compute result words of one command and queue them
  function automatic void predict_words(logic [2:0] c, logic [31:0] tv, logic [30:0] pr,
                                        logic [4:0] sl, logic [31:0] us,
                                        logic [15:0] ow);
    int s, pos, taken;
    longint diff, wt;
    logic [31:0] fire;
    logic [1:0] st;
    case (c)
      CMD_ADD_ONE, CMD_ADD_PER: begin
        if (m_free.size() > 0) s = m_free.pop_back();
        else if (m_high < MAX_TIMERS) begin
          s = m_high; m_high++;
        end else begin
          expected_words.push_back(mk_word(KIND_STATUS, ST_FULL, 0, 0, 0, 1));
          return;
        end
        m_due[s] = tv; m_user[s] = us; m_owner[s] = ow; m_reload[s] = pr;
        m_cancelled[s] = 0;
        m_mode[s] = (c == CMD_ADD_PER) ? MODE_PER : MODE_ONE;
        order_insert(s);
        expected_words.push_back(mk_word(KIND_SLOT, ST_OK, 5'(s), 0, 0, 1));
      end
      CMD_CANCEL: begin
        if (sl >= m_high || m_mode[sl] == MODE_FREE) st = ST_NO_TIMER;
        else if (m_cancelled[sl] || m_owner[sl] != ow) st = ST_OWNER;
        else begin
          m_mode[sl] = MODE_ONE; m_cancelled[sl] = 1; st = ST_OK;
        end
        expected_words.push_back(mk_word(KIND_STATUS, st, sl, 0, 0, 1));
      end
      CMD_DELAY: begin
        if (sl >= m_high || m_mode[sl] == MODE_FREE) begin
          expected_words.push_back(mk_word(KIND_STATUS, ST_NO_TIMER, sl, 0, 0, 1));
          return;
        end
        foreach (m_order[i]) if (m_order[i] == sl) begin
          m_order.delete(i);
          break;
        end
        m_due[sl] = m_due[sl] + tv;
        order_insert(sl);
        expected_words.push_back(mk_word(KIND_STATUS, ST_OK, sl, 0, m_due[sl], 1));
      end
      CMD_TICK: begin
        taken = 0;
        forever begin
          if (m_order.size() == 0) begin
            wt = m_idle; break;
          end
          pos = 0;
          // wrap fix: latest timer near the top of the range moves to zero
          if (tv < WRAP_NEAR_ZERO) begin
            s = m_order[m_order.size() - 1];
            if (m_due[s] == 0 || m_due[s] > WRAP_NEAR_TOP) begin
              m_due[s] = 0; pos = m_order.size() - 1;
            end
          end
          s = m_order[pos];
          diff = wrap_diff(m_due[s], tv);
          if (diff > 0) begin
            wt = diff; break;
          end
          if (taken >= MAX_TIMERS) begin
            wt = 0; break;
          end
          m_order.delete(pos);
          taken++;
          fire = (diff < -longint'(m_late)) ? tv : m_due[s];
          if (!m_cancelled[s])
            expected_words.push_back(mk_word(KIND_EXPIRY, ST_OK, 5'(s), m_user[s], fire, 0));
          if (m_mode[s] == MODE_PER) begin
            m_due[s] = fire + {1'b0, m_reload[s]};
            order_insert(s);
          end else release_slot(s);
        end
        if (wt < longint'(m_min)) wt = m_min;
        else if (wt > longint'(m_max)) wt = m_max;
        expected_words.push_back(mk_word(KIND_WAIT, ST_OK, 0, 0, wt[31:0], 1));
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, res_t got, res_t exp);
    errors++;
    $display("ERROR %0t: %s got k%0d s%0d sl%0d u%h t%h l%0d exp k%0d s%0d sl%0d u%h t%h l%0d",
             $realtime, what, got.kind, got.status, got.slot, got.user, got.tval, got.last,
             exp.kind, exp.status, exp.slot, exp.user, exp.tval, exp.last);
  endtask

  // check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    res_t got, exp;
    if (!rst && out_valid && !out_stall) begin
      got = mk_word(result_kind, status, slot_out, user_out, time_out, last);
      if (expected_words.size() == 0) report_mismatch("unexpected word", got, got);
      else begin
        exp = expected_words.pop_front();
        if (got !== exp) report_mismatch("field mismatch", got, exp);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (!all_sent || expected_words.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sorted_timer_scheduler: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off_req = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_word(logic [2:0] c, logic [31:0] tv, logic [30:0] pr,
                           logic [4:0] sl, logic [31:0] us, logic [15:0] ow, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c; time_value <= tv; period <= pr;
    timer_slot <= sl; user_id <= us; owner_tag <= ow;
    predict_words(c, tv, pr, sl, us, ow);
    @(posedge clk iff !in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk iff expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    set_register(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t row(logic [2:0] c, logic [31:0] tv, logic [30:0] pr,
                                    logic [4:0] sl, logic [31:0] us, logic [15:0] ow);
    stim_row_t r;
    r.cmd = c; r.tval = tv; r.per = pr; r.slot = sl; r.user = us; r.owner = ow;
    r.has_fixed = 0; r.fixed = '0;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(stim_row_t r, res_t f);
    r.has_fixed = 1; r.fixed = f;
    return r;
  endfunction

  // random command mix driven from a live set of slots
  task automatic random_phase(int count, bit busy_recv);
    int k, sel, s;
    logic [2:0] c;
    logic [31:0] tv;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      s = (m_high > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, m_high - 1)
                                                   : $urandom_range(0, 31);
      if (sel < 30) begin
        c = ($urandom_range(0, 1)) ? CMD_ADD_PER : CMD_ADD_ONE;
        tv = clock_now + $urandom_range(0, 2000) - (($urandom_range(0, 7) == 0) ? 3000 : 0);
        if ($urandom_range(0, 15) == 0) tv = $urandom();
        send_word(c, tv, ($urandom_range(0, 7) == 0) ? 31'($urandom()) :
                  31'($urandom_range(1, 1500)), 0, $urandom(),
                  ($urandom_range(0, 1)) ? m_owner[s] : 16'($urandom()),
                  $urandom_range(0, 6));
      end else if (sel < 42) begin
        send_word(CMD_CANCEL, $urandom(), 31'($urandom()), s, $urandom(),
                  ($urandom_range(0, 3) != 0) ? m_owner[s] : 16'($urandom()),
                  $urandom_range(0, 6));
      end else if (sel < 55) begin
        send_word(CMD_DELAY, ($urandom_range(0, 9) == 0) ? $urandom() :
                  32'($urandom_range(0, 800)), 31'($urandom()), s, $urandom(),
                  16'($urandom()), $urandom_range(0, 6));
      end else if (sel < 96) begin
        clock_now = clock_now + $urandom_range(0, 900);
        if ($urandom_range(0, 19) == 0) clock_now = clock_now + 2500;
        send_word(CMD_TICK, clock_now, 31'($urandom()), 5'($urandom()), $urandom(),
                  16'($urandom()), busy_recv ? 0 : $urandom_range(0, 6));
      end else begin
        send_word(3'($urandom_range(5, 7)), $urandom(), 31'($urandom()), 5'($urandom()),
                  $urandom(), 16'($urandom()), $urandom_range(0, 6));
      end
    end
  endtask

  initial begin
    stim_row_t plan [$];
    res_t       tail;
    int         n;
    errors = 0; all_sent = 0; hold_off_req = 0; clock_now = 32'd5000;
    m_high = 0;
    foreach (m_mode[i]) begin
      m_mode[i] = MODE_FREE; m_cancelled[i] = 0; m_due[i] = 0; m_reload[i] = 0;
      m_user[i] = 0; m_owner[i] = 0;
    end
    m_min = MIN_WAIT_RST; m_max = MAX_WAIT_RST;
    m_late = LATE_LIMIT_RST; m_idle = IDLE_WAIT_RST;
    rst = 1'b1; cfg_we = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
    command = 0; time_value = 0; period = 0; timer_slot = 0; user_id = 0; owner_tag = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    plan.push_back(fixed_row(row(CMD_TICK, 0, 0, 0, 0, 0),
                   mk_word(KIND_WAIT, ST_OK, 0, 0, 32'd500, 1)));
    plan.push_back(fixed_row(row(CMD_CANCEL, 0, 0, 5'd31, 0, 0),
                   mk_word(KIND_STATUS, ST_NO_TIMER, 5'd31, 0, 0, 1)));
    plan.push_back(fixed_row(row(CMD_ADD_ONE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0,
                   32'hFFFF_FFFF, 16'hFFFF), mk_word(KIND_SLOT, ST_OK, 0, 0, 0, 1)));
    plan.push_back(row(CMD_ADD_PER, 32'd100, 31'd1, 0, 32'h1234_5678, 16'h0001));
    plan.push_back(row(CMD_ADD_ONE, 32'd100, 31'd7, 0, 32'h0, 16'h0002));
    plan.push_back(row(CMD_CANCEL, 0, 0, 5'd1, 0, 16'h0009));
    plan.push_back(row(CMD_CANCEL, 0, 0, 5'd2, 0, 16'h0002));
    plan.push_back(row(CMD_CANCEL, 0, 0, 5'd2, 0, 16'h0002));
    plan.push_back(row(CMD_DELAY, 32'd50, 0, 5'd1, 0, 0));
    plan.push_back(row(CMD_DELAY, 32'hFFFF_FFFF, 0, 5'd0, 0, 0));
    plan.push_back(row(CMD_DELAY, 32'd1, 0, 5'd20, 0, 0));
    plan.push_back(row(CMD_ADD_ONE, 32'hFC00_0000, 31'd3, 0, 32'hA5A5_A5A5, 16'h0003));
    plan.push_back(row(CMD_TICK, 32'd10, 0, 0, 0, 0));
    plan.push_back(row(CMD_TICK, 32'd5000, 0, 0, 0, 0));
    plan.push_back(row(CMD_TICK, 32'd5200, 0, 0, 0, 0));
    plan.push_back(row(3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 5'd31, 32'hFFFF_FFFF, 16'hFFFF));
    foreach (plan[i]) begin
      send_word(plan[i].cmd, plan[i].tval, plan[i].per, plan[i].slot, plan[i].user,
                plan[i].owner, $urandom_range(0, 2));
      if (plan[i].has_fixed) begin
        tail = expected_words[expected_words.size() - 1];
        if (tail !== plan[i].fixed) report_mismatch("directed row", tail, plan[i].fixed);
      end
    end
    wait_drained();

    // fill the table, hit full, then fire all at one tick with a tight late limit
    write_reg(REG_LATE_LIMIT, 16'd0);
    write_reg(REG_MIN_WAIT, 16'd0);
    write_reg(REG_MAX_WAIT, 16'hFFFF);
    n = MAX_TIMERS - m_high + m_free.size() + 1;
    for (int k = 0; k < n; k++)
      send_word(k[0] ? CMD_ADD_PER : CMD_ADD_ONE, 32'd6000 + (k % 3), 31'd1, 0,
                $urandom(), 16'(k), $urandom_range(0, 2));
    wait_drained();
    clock_now = 32'd9000;
    send_word(CMD_TICK, clock_now, 0, 0, 0, 0, 0);
    send_word(CMD_TICK, clock_now, 0, 0, 0, 0, 0);
    wait_drained();

    // receiver holds off while sender keeps feeding, then sender pauses
    write_reg(REG_IDLE_WAIT, 16'hFFFF);
    write_reg(REG_LATE_LIMIT, 16'hFFFF);
    hold_off_req = 1;
    random_phase(20, 1);
    wait_drained();

    write_reg(REG_MIN_WAIT, 16'd600);
    write_reg(REG_MAX_WAIT, 16'd100);
    write_reg(REG_LATE_LIMIT, 16'd300);
    write_reg(REG_IDLE_WAIT, 16'd0);
    random_phase(15, 0);
    wait_drained();

    write_reg(REG_MIN_WAIT, 16'd50);
    write_reg(REG_MAX_WAIT, 16'd500);
    write_reg(REG_LATE_LIMIT, 16'd1000);
    random_phase(15, 0);
    wait_drained();
    all_sent = 1;

    if (errors == 0 && expected_words.size() == 0)
      $display("sorted_timer_scheduler: match");
    else
      $display("sorted_timer_scheduler: mismatch");
    $finish;
  end

endmodule
